>>> design/sprm_pkg.sv
// Shared types and constants for the SPI register access master.
`default_nettype none

package sprm_pkg;

    localparam int BYTE_BITS = 8;
    localparam int ADDR_BITS = BYTE_BITS - 1;
    localparam int BIT_IDX_W = $clog2(BYTE_BITS);

    localparam logic [BYTE_BITS-1:0] CS_SETUP_RESET = 8'd50;

    typedef enum logic [1:0] {
        ACT_TICK  = 2'd0,
        ACT_READ  = 2'd1,
        ACT_WRITE = 2'd2,
        ACT_NONE  = 2'd3
    } sprm_action_t;

    typedef struct packed {
        logic [BYTE_BITS-1:0] read_data;
        logic                 done_res;
        logic                 busy_res;
        logic                 mosi;
        logic                 sck;
        logic                 cs_n;
    } sprm_result_t;

endpackage

`default_nettype wire

>>> design/sprm_engine.sv
// Transaction sequencer: advances the pin state by one half-period tick per step.
`default_nettype none

module sprm_engine (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          step,
    input  wire logic [1:0]                    action,
    input  wire logic [sprm_pkg::ADDR_BITS-1:0] reg_addr,
    input  wire logic [sprm_pkg::BYTE_BITS-1:0] write_data,
    input  wire logic                          miso,
    input  wire logic [sprm_pkg::BYTE_BITS-1:0] cs_setup_ticks,
    output sprm_pkg::sprm_result_t             result
);
    import sprm_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_SETUP = 3'd1,
        PH_ADDR  = 3'd2,
        PH_WDATA = 3'd3,
        PH_RDATA = 3'd4,
        PH_END   = 3'd5
    } phase_t;

    localparam logic [BIT_IDX_W-1:0] LAST_BIT = BIT_IDX_W'(BYTE_BITS - 1);

    phase_t                 phase_reg,     phase_next;
    logic [BIT_IDX_W-1:0]   bit_index_reg, bit_index_next;
    logic                   half_reg,      half_next;
    logic [BYTE_BITS-1:0]   delay_reg,     delay_next;
    logic [BYTE_BITS-1:0]   tx_reg,        tx_next;
    logic [BYTE_BITS-1:0]   pending_reg,   pending_next;
    logic [BYTE_BITS-1:0]   rx_reg,        rx_next;
    logic                   is_read_reg,   is_read_next;
    logic [BYTE_BITS-1:0]   hold_reg,      hold_next;
    logic                   cs_n, sck, mosi, busy, done;
    logic                   start_rd;

    assign start_rd = (action == ACT_READ);

    always_comb begin
        phase_next     = phase_reg;
        bit_index_next = bit_index_reg;
        half_next      = half_reg;
        delay_next     = delay_reg;
        tx_next        = tx_reg;
        pending_next   = pending_reg;
        rx_next        = rx_reg;
        is_read_next   = is_read_reg;
        hold_next      = hold_reg;
        cs_n = 1'b0;
        sck  = 1'b0;
        mosi = 1'b0;
        busy = 1'b1;
        done = 1'b0;
        case (phase_reg)
            PH_SETUP: begin
                if (delay_reg != '0) begin
                    delay_next = delay_reg - 1'b1;
                end
                if (delay_next == '0) begin
                    phase_next     = PH_ADDR;
                    bit_index_next = '0;
                    half_next      = 1'b0;
                end
            end
            PH_ADDR, PH_WDATA: begin
                mosi = tx_reg[BYTE_BITS-1];
                if (!half_reg) begin
                    half_next = 1'b1;
                end else begin
                    sck       = 1'b1;
                    tx_next   = {tx_reg[BYTE_BITS-2:0], 1'b0};
                    half_next = 1'b0;
                    if (bit_index_reg == LAST_BIT) begin
                        bit_index_next = '0;
                        if (phase_reg == PH_WDATA) begin
                            phase_next = PH_END;
                        end else if (is_read_reg) begin
                            phase_next = PH_RDATA;
                            rx_next    = '0;
                        end else begin
                            phase_next = PH_WDATA;
                            tx_next    = pending_reg;
                        end
                    end else begin
                        bit_index_next = bit_index_reg + 1'b1;
                    end
                end
            end
            PH_RDATA: begin
                if (!half_reg) begin
                    half_next = 1'b1;
                end else begin
                    sck       = 1'b1;
                    rx_next   = {rx_reg[BYTE_BITS-2:0], miso};
                    half_next = 1'b0;
                    if (bit_index_reg == LAST_BIT) begin
                        bit_index_next = '0;
                        phase_next     = PH_END;
                    end else begin
                        bit_index_next = bit_index_reg + 1'b1;
                    end
                end
            end
            PH_END: begin
                cs_n = 1'b1;
                busy = 1'b0;
                done = 1'b1;
                if (is_read_reg) begin
                    hold_next = rx_reg;
                end
                phase_next     = PH_IDLE;
                bit_index_next = '0;
                half_next      = 1'b0;
            end
            default: begin
                phase_next     = PH_IDLE;
                bit_index_next = '0;
                half_next      = 1'b0;
                if (action == ACT_READ || action == ACT_WRITE) begin
                    is_read_next = start_rd;
                    tx_next      = {start_rd, reg_addr};
                    pending_next = write_data;
                    delay_next   = cs_setup_ticks;
                    phase_next   = (cs_setup_ticks != '0) ? PH_SETUP : PH_ADDR;
                end else begin
                    cs_n = 1'b1;
                    busy = 1'b0;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_IDLE;
            bit_index_reg <= '0;
            half_reg      <= 1'b0;
            delay_reg     <= '0;
            tx_reg        <= '0;
            pending_reg   <= '0;
            rx_reg        <= '0;
            is_read_reg   <= 1'b0;
            hold_reg      <= '0;
        end else if (step) begin
            phase_reg     <= phase_next;
            bit_index_reg <= bit_index_next;
            half_reg      <= half_next;
            delay_reg     <= delay_next;
            tx_reg        <= tx_next;
            pending_reg   <= pending_next;
            rx_reg        <= rx_next;
            is_read_reg   <= is_read_next;
            hold_reg      <= hold_next;
        end
    end

    always_comb begin
        result.cs_n      = cs_n;
        result.sck       = sck;
        result.mosi      = mosi;
        result.busy_res  = busy;
        result.done_res  = done;
        result.read_data = hold_next;
    end

endmodule

`default_nettype wire

>>> design/spi_register_access_master_unit.sv
// Top level of the SPI register access master: request register, sequencer, result register.
//
//  channel   | dir | handshake            | payload
//  s_ (tick) | in  | s_tvalid / s_tready  | s_tuser: action; s_tdata: reg_addr, write_data, miso
//  m_ (pins) | out | m_tvalid / m_tready  | m_tdata: cs_n, sck, mosi, busy_res, done_res, read_data
//  cfg       | in  | cfg_we               | cfg_wdata: cs_setup_ticks
//
// One request per cycle sustained while the m_ side accepts; each request yields one result
// through the request register, then sequencer logic into the result register.
// Reset puts the sequencer idle, chip select high, cs_setup_ticks at 50.
// A stalled m_ side holds the result register; the request register holds behind it,
// and s_tready drops only when both are full.
`default_nettype none

module spi_register_access_master_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output      logic        s_tready,
    input  wire logic [1:0]  s_tuser,   // [1:0] action
    input  wire logic [15:0] s_tdata,   // [6:0] reg_addr, [14:7] write_data, [15] miso
    output      logic        m_tvalid,
    input  wire logic        m_tready,
    output      logic [15:0] m_tdata,   // [0] cs_n, [1] sck, [2] mosi, [3] busy_res,
                                        // [4] done_res, [12:5] read_data, [15:13] zero
    input  wire logic        cfg_we,
    input  wire logic [7:0]  cfg_wdata  // cs_setup_ticks
);
    import sprm_pkg::*;

    logic                 in_valid_reg;
    logic [1:0]           in_action_reg;
    logic [15:0]          in_data_reg;
    logic                 out_valid_reg;
    sprm_result_t         res_reg;
    sprm_result_t         res_next;
    logic [BYTE_BITS-1:0] cs_setup_reg;
    logic                 out_ready;
    logic                 fire;

    assign out_ready = !out_valid_reg || m_tready;
    assign fire      = in_valid_reg && out_ready;
    assign s_tready  = !in_valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cs_setup_reg <= CS_SETUP_RESET;
        end else if (cfg_we) begin
            cs_setup_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_action_reg <= s_tuser;
            in_data_reg   <= s_tdata;
        end
    end

    sprm_engine u_engine (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .step           (fire),
        .action         (in_action_reg),
        .reg_addr       (in_data_reg[ADDR_BITS-1:0]),
        .write_data     (in_data_reg[ADDR_BITS+BYTE_BITS-1:ADDR_BITS]),
        .miso           (in_data_reg[15]),
        .cs_setup_ticks (cs_setup_reg),
        .result         (res_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_ready) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            res_reg <= res_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, res_reg};

`ifndef SYNTHESIS
    a_done_not_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && res_reg.done_res |-> !res_reg.busy_res && res_reg.cs_n)
        else $error("done reported while busy or with chip select low");

    a_cs_low_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !res_reg.cs_n |-> res_reg.busy_res)
        else $error("chip select low outside a transaction");

    a_sck_needs_cs: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && res_reg.sck |-> !res_reg.cs_n)
        else $error("serial clock high with chip select high");

    a_stall_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> out_valid_reg && in_valid_reg && !m_tready)
        else $error("request side stalled with room to advance");
`endif

endmodule

`default_nettype wire
